/* hdl/rbd_pkg.sv */
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and codes shared by the 2x2 RGBA8 box downsampler modules.
// ----------------------------------------------------------------------------
package rbd_pkg;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rbd_pix_t;

  typedef struct packed {
    logic [8:0] alpha;
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } rbd_pair_t;

  typedef logic [1:0] rbd_kind_t;

  localparam rbd_kind_t KIND_WRITE  = 2'd0;
  localparam rbd_kind_t KIND_READ   = 2'd1;
  localparam rbd_kind_t KIND_DIRECT = 2'd2;

  typedef struct packed {
    rbd_kind_t kind;
    logic      done;
    rbd_pair_t pair;
  } rbd_op_t;

endpackage

/* hdl/rbd_front.sv */
// ----------------------------------------------------------------------------
// rbd_front
// Accepts source pixels, tracks column and row, forms horizontal pair sums
// and classifies each pair as a line write, a line read or a direct result.
// ----------------------------------------------------------------------------
module rbd_front #(
  parameter int COL_W = 12,
  parameter int IDX_W = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic [COL_W-1:0]    width_last,
  input  logic [IDX_W-1:0]    dst_col_last,
  input  logic [15:0]         height_last,
  input  logic [14:0]         dst_row_last,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  rbd_pkg::rbd_pix_t   s_tdata,
  input  logic                q_full,
  output logic                push,
  output rbd_pkg::rbd_op_t    push_op,
  output logic [IDX_W-1:0]    push_idx
);
  import rbd_pkg::*;

  logic [COL_W-1:0] col;
  logic [15:0]      row;
  rbd_pix_t         held;
  logic             accept;
  logic             have_pair;
  rbd_pair_t        pair;
  rbd_kind_t        kind;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;

  always_comb begin
    have_pair = 1'b0;
    pair      = '0;
    if (width_last == '0) begin
      have_pair  = 1'b1;
      pair.red   = {s_tdata.red, 1'b0};
      pair.green = {s_tdata.green, 1'b0};
      pair.blue  = {s_tdata.blue, 1'b0};
      pair.alpha = {s_tdata.alpha, 1'b0};
    end else if (col[0]) begin
      have_pair  = 1'b1;
      pair.red   = {1'b0, held.red} + {1'b0, s_tdata.red};
      pair.green = {1'b0, held.green} + {1'b0, s_tdata.green};
      pair.blue  = {1'b0, held.blue} + {1'b0, s_tdata.blue};
      pair.alpha = {1'b0, held.alpha} + {1'b0, s_tdata.alpha};
    end
    if (height_last == '0) begin
      kind = KIND_DIRECT;
    end else if (row[0]) begin
      kind = KIND_READ;
    end else begin
      kind = KIND_WRITE;
    end
  end

  assign push          = accept && have_pair;
  assign push_idx      = IDX_W'(col >> 1);
  assign push_op.kind  = kind;
  assign push_op.pair  = pair;
  assign push_op.done  = (push_idx == dst_col_last) && (row[15:1] == dst_row_last);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == width_last) begin
        col <= '0;
        row <= (row == height_last) ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !col[0]) begin
      held <= s_tdata;
    end
  end

endmodule

/* hdl/rbd_queue.sv */
// ----------------------------------------------------------------------------
// rbd_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module rbd_queue #(
  parameter int DATA_W = 50,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] pop_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/rbd_back.sv */
// ----------------------------------------------------------------------------
// rbd_back
// Executes queued pair requests against the line store and produces the
// rounded 2x2 averages through a read stage and an output register.
// ----------------------------------------------------------------------------
module rbd_back #(
  parameter int IDX_W      = 11,
  parameter int LINE_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  rbd_pkg::rbd_op_t   q_op,
  input  logic [IDX_W-1:0]   q_idx,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output rbd_pkg::rbd_pix_t  m_tdata,
  output logic               m_tlast
);
  import rbd_pkg::*;

  function automatic logic [7:0] avg4(input logic [9:0] blk);
    logic [10:0] sum;
    sum = {1'b0, blk} + 11'd2;
    return sum[9:2];
  endfunction

  rbd_pair_t line_mem [LINE_DEPTH];
  rbd_pair_t rd_pair;
  rbd_pair_t a_pair;
  rbd_kind_t a_kind;
  logic      a_done;
  logic      a_valid;
  logic      a_ready;
  logic      out_adv;
  logic      is_write;
  logic      mem_we;
  logic      mem_re;
  logic [9:0] blk_r;
  logic [9:0] blk_g;
  logic [9:0] blk_b;
  logic [9:0] blk_a;

  assign out_adv  = !m_tvalid || m_tready;
  assign a_ready  = !a_valid || out_adv;
  assign is_write = (q_op.kind == KIND_WRITE);
  assign pop      = q_valid && (is_write || a_ready);
  assign mem_we   = pop && is_write;
  assign mem_re   = pop && (q_op.kind == KIND_READ);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[q_idx] <= q_op.pair;
    end
    if (mem_re) begin
      rd_pair <= line_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop && !is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && pop && !is_write) begin
      a_pair <= q_op.pair;
      a_kind <= q_op.kind;
      a_done <= q_op.done;
    end
  end

  always_comb begin
    if (a_kind == KIND_READ) begin
      blk_r = {1'b0, rd_pair.red} + {1'b0, a_pair.red};
      blk_g = {1'b0, rd_pair.green} + {1'b0, a_pair.green};
      blk_b = {1'b0, rd_pair.blue} + {1'b0, a_pair.blue};
      blk_a = {1'b0, rd_pair.alpha} + {1'b0, a_pair.alpha};
    end else begin
      blk_r = {a_pair.red, 1'b0};
      blk_g = {a_pair.green, 1'b0};
      blk_b = {a_pair.blue, 1'b0};
      blk_a = {a_pair.alpha, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid) begin
      m_tdata.red   <= avg4(blk_r);
      m_tdata.green <= avg4(blk_g);
      m_tdata.blue  <= avg4(blk_b);
      m_tdata.alpha <= avg4(blk_a);
      m_tlast       <= a_done;
    end
  end

endmodule

/* hdl/rgba8_box_downsample_2x2.sv */
// ----------------------------------------------------------------------------
// rgba8_box_downsample_2x2
// Streaming 2x2 box filter that halves an RGBA8 image in both directions.
// ----------------------------------------------------------------------------
// Source pixels enter on the s_ stream in raster order, one per request, and
// the block emits one averaged pixel per complete 2x2 block on the m_ stream,
// each channel rounded as (sum + 2) / 4. An odd last column or row is dropped;
// a width or height of one counts its edge twice. m_tlast marks the last
// output pixel of an image, after which the counters wrap for the next image.
// The source size is set over the APB port at addresses 0 (width) and 4
// (height) while the block is idle; any write restarts the image position.
// Throughput is one source pixel per clock while the queue is not full. The
// pixel that completes a block is handled in order: the front
// pushes into a four-entry queue, the back end reads the line store through
// a registered port, and the output register holds the result. When the
// receiver stalls, the output register and read stage hold, the queue fills
// behind a read or direct request, and s_tready falls once it is full. Reset
// clears the counters and the queue; the line store needs no clearing because
// an odd row only reads entries written by the even row above it.
// ----------------------------------------------------------------------------
module rgba8_box_downsample_2x2 #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  rbd_pkg::rbd_pix_t  s_tdata,   // red_in, green_in, blue_in, alpha_in
  output logic               m_tvalid,
  input  logic               m_tready,
  output rbd_pkg::rbd_pix_t  m_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rbd_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ENTRY_W    = IDX_W + $bits(rbd_op_t);

  logic [12:0]      source_width;
  logic [15:0]      source_height;
  logic [COL_W-1:0] width_last;
  logic [IDX_W-1:0] dst_col_last;
  logic [15:0]      height_last;
  logic [14:0]      dst_row_last;
  logic             cfg_wr;
  logic [31:0]      w_eff;
  logic [31:0]      h_eff;

  logic             q_full;
  logic             push;
  rbd_op_t          push_op;
  logic [IDX_W-1:0] push_idx;
  logic             q_valid;
  logic             pop;
  logic [ENTRY_W-1:0] q_data;
  rbd_op_t          q_op;
  logic [IDX_W-1:0] q_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {16'd0, source_height} : {19'd0, source_width};

  always_comb begin
    if (pwdata[12:0] == 13'd0) begin
      w_eff = 32'd1;
    end else if ({19'd0, pwdata[12:0]} > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = {19'd0, pwdata[12:0]};
    end
    h_eff = (pwdata[15:0] == 16'd0) ? 32'd1 : {16'd0, pwdata[15:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 13'd1;
      source_height <= 16'd1;
      width_last    <= '0;
      dst_col_last  <= '0;
      height_last   <= '0;
      dst_row_last  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        source_height <= pwdata[15:0];
        height_last   <= 16'(h_eff - 32'd1);
        dst_row_last  <= (h_eff > 32'd1) ? 15'((h_eff >> 1) - 32'd1) : 15'd0;
      end else begin
        source_width <= pwdata[12:0];
        width_last   <= COL_W'(w_eff - 32'd1);
        dst_col_last <= (w_eff > 32'd1) ? IDX_W'((w_eff >> 1) - 32'd1) : '0;
      end
    end
  end

  rbd_front #(
    .COL_W(COL_W),
    .IDX_W(IDX_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_wr),
    .width_last   (width_last),
    .dst_col_last (dst_col_last),
    .height_last  (height_last),
    .dst_row_last (dst_row_last),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op),
    .push_idx     (push_idx)
  );

  rbd_queue #(
    .DATA_W(ENTRY_W),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_idx, push_op}),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  assign q_op  = q_data[$bits(rbd_op_t)-1:0];
  assign q_idx = q_data[ENTRY_W-1:$bits(rbd_op_t)];

  rbd_back #(
    .IDX_W     (IDX_W),
    .LINE_DEPTH(LINE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_idx    (q_idx),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
